### rtl/core/png_scanline_unfilter_to_rgb_top_assert.svh
// Assertion macros used by the top file to check its own logic.
`ifndef PNG_SCANLINE_UNFILTER_TO_RGB_TOP_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_TO_RGB_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/psu_pkg.sv
`default_nettype none

package psu_pkg;

    localparam logic [1:0] FMT_GRAY       = 2'd0;
    localparam logic [1:0] FMT_RGB        = 2'd1;
    localparam logic [1:0] FMT_GRAY_ALPHA = 2'd2;
    localparam logic [1:0] FMT_RGBA       = 2'd3;

    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FORMAT = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] sample;
        logic [1:0] chan;
        logic [7:0] filter;
        logic       first_row;
        logic       row_start;
        logic       emit;
        logic       gray;
        logic       row_done;
        logic       image_done;
    } entry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

    function automatic logic [2:0] chan_count(input logic [1:0] fmt);
        logic [2:0] n;
        unique case (fmt)
            FMT_GRAY:       n = 3'd1;
            FMT_RGB:        n = 3'd3;
            FMT_GRAY_ALPHA: n = 3'd2;
            FMT_RGBA:       n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] p;
        logic signed [10:0] pa;
        logic signed [10:0] pb;
        logic signed [10:0] pc;
        logic [7:0]         r;
        p  = signed'({3'b000, a}) + signed'({3'b000, b}) - signed'({3'b000, c});
        pa = p - signed'({3'b000, a});
        pb = p - signed'({3'b000, b});
        pc = p - signed'({3'b000, c});
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) r = a;
        else if (pb <= pc)        r = b;
        else                      r = c;
        return r;
    endfunction

    function automatic logic [7:0] predict(input logic [7:0] filter, input logic [7:0] a,
                                           input logic [7:0] b, input logic [7:0] c);
        logic [8:0] sum;
        logic [7:0] pred;
        sum = {1'b0, a} + {1'b0, b};
        case (filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum[8:1];
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 8'd0;
        endcase
        return pred;
    endfunction

endpackage

`default_nettype wire

### rtl/core/psu_front.sv
`default_nettype none

module psu_front
    import psu_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int LINE_DEPTH = 4 * MAX_WIDTH,
    localparam int AW = $clog2(LINE_DEPTH),
    localparam int CW = $clog2(LINE_DEPTH + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [10:0]   cfg_width,
    input  wire logic [15:0]   cfg_height,
    input  wire logic [1:0]    cfg_format,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    byte_value,
    output logic               q_push,
    output logic [AW-1:0]      q_x,
    output entry_t             q_entry,
    input  wire queue_status_t q_stat
);

    localparam int XW = (CW > 11) ? CW : 11;

    logic          awaiting_reg, awaiting_next;
    logic          row_start_reg, row_start_next;
    logic          first_row_reg, first_row_next;
    logic [15:0]   row_index_reg, row_index_next;
    logic [CW-1:0] column_reg, column_next;
    logic [1:0]    mod3_reg, mod3_next;
    logic [7:0]    filter_reg, filter_next;

    logic [XW-1:0] width_x;
    logic [XW-1:0] width_c;
    logic [CW-1:0] width_w;
    logic [CW-1:0] row_len;
    logic          clamp;
    logic [CW-1:0] x;
    logic [1:0]    chan;
    logic [2:0]    ch;
    logic          row_done;
    logic [15:0]   height_eff;
    logic          last_row;
    logic          accept;
    logic          sample_fire;

    assign in_ready    = awaiting_reg || !q_stat.full;
    assign accept      = in_valid && in_ready;
    assign sample_fire = accept && !awaiting_reg;

    always_comb
    begin
        width_x = XW'(cfg_width);
        if (width_x == '0)
        begin
            width_c = XW'(1);
        end
        else if (width_x > XW'(MAX_WIDTH))
        begin
            width_c = XW'(MAX_WIDTH);
        end
        else
        begin
            width_c = width_x;
        end
        width_w = CW'(width_c);
        unique case (cfg_format)
            FMT_GRAY:       row_len = width_w;
            FMT_GRAY_ALPHA: row_len = width_w << 1;
            FMT_RGB:        row_len = width_w + (width_w << 1);
            FMT_RGBA:       row_len = width_w << 2;
        endcase
        clamp = (column_reg >= row_len);
        x     = clamp ? (row_len - CW'(1)) : column_reg;
        unique case (cfg_format)
            FMT_GRAY:       chan = 2'd0;
            FMT_GRAY_ALPHA: chan = {1'b0, x[0]};
            FMT_RGB:        chan = clamp ? 2'd2 : mod3_reg;
            FMT_RGBA:       chan = x[1:0];
        endcase
        ch         = chan_count(cfg_format);
        row_done   = ({1'b0, x} + (CW + 1)'(1)) >= {1'b0, row_len};
        height_eff = (cfg_height == 16'd0) ? 16'd1 : cfg_height;
        last_row   = ({1'b0, row_index_reg} + 17'd1) >= {1'b0, height_eff};
    end

    always_comb
    begin
        q_push               = sample_fire;
        q_x                  = x[AW-1:0];
        q_entry.sample       = byte_value;
        q_entry.chan         = chan;
        q_entry.filter       = filter_reg;
        q_entry.first_row    = first_row_reg;
        q_entry.row_start    = row_start_reg;
        q_entry.emit         = ({1'b0, chan} == (ch - 3'd1));
        q_entry.gray         = (ch < 3'd3);
        q_entry.row_done     = row_done;
        q_entry.image_done   = row_done && last_row;
    end

    always_comb
    begin
        awaiting_next  = awaiting_reg;
        row_start_next = row_start_reg;
        first_row_next = first_row_reg;
        row_index_next = row_index_reg;
        column_next    = column_reg;
        mod3_next      = mod3_reg;
        filter_next    = filter_reg;
        if (accept && awaiting_reg)
        begin
            filter_next    = byte_value;
            awaiting_next  = 1'b0;
            column_next    = '0;
            mod3_next      = 2'd0;
            row_start_next = 1'b1;
        end
        else if (sample_fire)
        begin
            row_start_next = 1'b0;
            if (row_done)
            begin
                awaiting_next  = 1'b1;
                column_next    = '0;
                mod3_next      = 2'd0;
                row_index_next = last_row ? 16'd0 : (row_index_reg + 16'd1);
                first_row_next = last_row;
            end
            else
            begin
                column_next = x + CW'(1);
                mod3_next   = (mod3_reg == 2'd2) ? 2'd0 : (mod3_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b1;
            row_start_reg <= 1'b0;
            first_row_reg <= 1'b1;
            row_index_reg <= 16'd0;
            column_reg    <= '0;
            mod3_reg      <= 2'd0;
            filter_reg    <= 8'd0;
        end
        else
        begin
            awaiting_reg  <= awaiting_next;
            row_start_reg <= row_start_next;
            first_row_reg <= first_row_next;
            row_index_reg <= row_index_next;
            column_reg    <= column_next;
            mod3_reg      <= mod3_next;
            filter_reg    <= filter_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/psu_queue.sv
`default_nettype none

module psu_queue
    import psu_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output queue_status_t         status
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slots [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == (PW + 1)'(QUEUE_DEPTH));
    assign status.valid = (count_reg != '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;
    assign pop_data     = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? (wr_ptr_reg + PW'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + PW'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PW + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/psu_back.sv
`default_nettype none

module psu_back
    import psu_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int LINE_DEPTH = 4 * MAX_WIDTH,
    localparam int AW = $clog2(LINE_DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire queue_status_t q_stat,
    input  wire logic [AW-1:0] q_x,
    input  wire entry_t        q_entry,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic               end_of_row,
    output logic               end_of_image
);

    logic [7:0]    line_mem [LINE_DEPTH];

    logic          s1_valid_reg, s1_valid_next;
    entry_t        s1_entry_reg;
    logic [AW-1:0] s1_x_reg;
    logic [7:0]    rdata_reg;
    logic          byp_reg;
    logic [7:0]    byp_val_reg;

    logic [7:0]    left_reg [4];
    logic [7:0]    left_next [4];
    logic [7:0]    above_left_reg [4];
    logic [7:0]    above_left_next [4];
    logic [7:0]    pix_reg [3];
    logic [7:0]    pix_next [3];

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    red_reg, green_reg, blue_reg;
    logic          eor_reg, eoi_reg;

    logic          s1_fire;
    logic          load_s1;
    logic [7:0]    a, b, c;
    logic [7:0]    recon;

    assign s1_fire = s1_valid_reg && (!s1_entry_reg.emit || !out_valid_reg || out_ready);
    assign load_s1 = q_stat.valid && (!s1_valid_reg || s1_fire);
    assign q_pop   = load_s1;

    always_comb
    begin
        a = s1_entry_reg.row_start ? 8'd0 : left_reg[s1_entry_reg.chan];
        c = s1_entry_reg.row_start ? 8'd0 : above_left_reg[s1_entry_reg.chan];
        if (s1_entry_reg.first_row)
        begin
            b = 8'd0;
        end
        else if (byp_reg)
        begin
            b = byp_val_reg;
        end
        else
        begin
            b = rdata_reg;
        end
        recon = s1_entry_reg.sample + predict(s1_entry_reg.filter, a, b, c);

        for (int i = 0; i < 4; i++)
        begin
            left_next[i]       = s1_entry_reg.row_start ? 8'd0 : left_reg[i];
            above_left_next[i] = s1_entry_reg.row_start ? 8'd0 : above_left_reg[i];
        end
        left_next[s1_entry_reg.chan]       = recon;
        above_left_next[s1_entry_reg.chan] = b;

        for (int i = 0; i < 3; i++)
        begin
            pix_next[i] = pix_reg[i];
        end
        if (s1_entry_reg.chan != 2'd3)
        begin
            pix_next[s1_entry_reg.chan] = recon;
        end

        s1_valid_next = load_s1 ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        if (s1_fire && s1_entry_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            line_mem[s1_x_reg] <= recon;
        end
        if (load_s1)
        begin
            rdata_reg <= line_mem[q_x];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_entry_reg <= q_entry;
            s1_x_reg     <= q_x;
            byp_reg      <= s1_fire && (s1_x_reg == q_x);
            byp_val_reg  <= recon;
        end
        if (s1_fire && s1_entry_reg.emit)
        begin
            red_reg   <= pix_next[0];
            green_reg <= s1_entry_reg.gray ? pix_next[0] : pix_next[1];
            blue_reg  <= s1_entry_reg.gray ? pix_next[0] : pix_next[2];
            eor_reg   <= s1_entry_reg.row_done;
            eoi_reg   <= s1_entry_reg.image_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                left_reg[i]       <= 8'd0;
                above_left_reg[i] <= 8'd0;
            end
            for (int i = 0; i < 3; i++)
            begin
                pix_reg[i] <= 8'd0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    left_reg[i]       <= left_next[i];
                    above_left_reg[i] <= above_left_next[i];
                end
                for (int i = 0; i < 3; i++)
                begin
                    pix_reg[i] <= pix_next[i];
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign end_of_row   = eor_reg;
    assign end_of_image = eoi_reg;

endmodule

`default_nettype wire

### rtl/core/png_scanline_unfilter_to_rgb_top.sv
// PNG scanline reconstruction to RGB pixels, 8-bit samples, non-interlaced.
// The input channel (in_valid, in_ready, byte_value) takes the decompressed
// image stream one item per clock while in_ready is high: a filter byte at
// the start of each row, then the row's samples. The output channel
// (out_valid, out_ready, red, green, blue, end_of_row, end_of_image)
// gives one item per completed pixel. Gray formats are copied to all three
// colors and alpha is dropped. Registers at byte addresses 0, 4 and 8 hold
// the width, height and format. The user must write them through the
// APB-style port only while the block is idle; the block itself does not
// enforce this. A byte that completes a pixel passes through the queue, then
// the stage that reads the line store and rebuilds the sample, then the
// output register. Throughput is one byte per clock while the receiver keeps
// up, and each row's filter byte takes an input slot of its own.
// When the receiver stalls, the output register holds its item, the
// reconstruction stage and the four-entry queue fill, and in_ready then
// drops. Reset starts a new image waiting for a filter byte, with the
// registers at width 1, height 1 and gray. The line store needs no clearing
// pass: the first row of an image ignores what it reads.
`default_nettype none

`include "png_scanline_unfilter_to_rgb_top_assert.svh"

module png_scanline_unfilter_to_rgb_top
    import psu_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:2]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic             end_of_row,
    output logic             end_of_image
);

    localparam int LINE_DEPTH = 4 * MAX_WIDTH;
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int QW = AW + $bits(entry_t);

    logic [10:0]   width_reg;
    logic [15:0]   height_reg;
    logic [1:0]    format_reg;
    logic          cfg_write;

    logic          q_push;
    logic          q_pop;
    logic [AW-1:0] push_x;
    entry_t        push_entry;
    logic [AW-1:0] pop_x;
    entry_t        pop_entry;
    logic [QW-1:0] pop_data;
    queue_status_t q_stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr)
            REG_WIDTH:  prdata = {21'd0, width_reg};
            REG_HEIGHT: prdata = {16'd0, height_reg};
            REG_FORMAT: prdata = {30'd0, format_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1;
            height_reg <= 16'd1;
            format_reg <= FMT_GRAY;
        end
        else if (cfg_write)
        begin
            unique case (paddr)
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[15:0];
                REG_FORMAT: format_reg <= pwdata[1:0];
                default:    ;
            endcase
        end
    end

    psu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .cfg_format (format_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .q_push     (q_push),
        .q_x        (push_x),
        .q_entry    (push_entry),
        .q_stat     (q_stat)
    );

    psu_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_x, push_entry}),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .status    (q_stat)
    );

    assign pop_x     = pop_data[QW-1 -: AW];
    assign pop_entry = entry_t'(pop_data[$bits(entry_t)-1:0]);

    psu_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_x          (pop_x),
        .q_entry      (pop_entry),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .end_of_row   (end_of_row),
        .end_of_image (end_of_image)
    );

    `PSU_ASSERT_NOW(a_no_push_when_full, q_push, !q_stat.full, "Push into a full queue.")
    `PSU_ASSERT_NOW(a_stall_means_full, in_valid && !in_ready, q_stat.full, "Input stall.")
    `PSU_ASSERT_NEXT(a_full_holds, q_stat.full && !q_pop, q_stat.full, "Queue lost an item.")
    `PSU_ASSERT_NOW(a_image_end_row_end, out_valid && end_of_image, end_of_row, "Bad image end.")

endmodule

`default_nettype wire
